>>> rtl/core/kftc_pkg.sv
// kftc_pkg: types and constants for the keyer and fan tick controller
// payload structs, register indexes, reset values and slot codes
// no dependencies
`default_nettype none

package kftc_pkg;

  localparam int KeyBitsDefault = 1024;

  localparam int SampleBits = 10;
  localparam logic [9:0] SampleMask = 10'((1 << SampleBits) - 1);

  localparam logic [3:0] FanStartupSlots = 4'd8;

  // command codes
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CfgSeqLength   = 2'd0;
  localparam logic [1:0] CfgFanOnThresh = 2'd1;
  localparam logic [1:0] CfgFanOffThresh = 2'd2;
  localparam logic [1:0] CfgPeriodBase  = 2'd3;

  // configuration reset values
  localparam logic [10:0] SeqLengthReset  = 11'd1;
  localparam logic [12:0] FanOnReset      = 13'd7017;
  localparam logic [12:0] FanOffReset     = 13'd7101;
  localparam logic [7:0]  PeriodBaseReset = 8'd145;

  // state reset values
  localparam logic [7:0] PeriodReset = 8'd122;

  // slot codes
  localparam logic [3:0] FanSlot    = 4'b1001;
  localparam logic [1:0] KeySlotLow = 2'b11;

  // accumulator limits
  localparam logic [12:0] TempSumMax  = 13'd8191;
  localparam logic [10:0] SpeedSumMax = 11'd2047;

  typedef struct packed {
    logic       command;
    logic [9:0] adc_sample;
    logic [9:0] bit_address;
    logic       bit_value;
  } in_item_t;

  typedef struct packed {
    logic       key_level;
    logic       fan_enable;
    logic [7:0] timer_period;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/keyer_fan_tick_controller_top.sv
// keyer_fan_tick_controller_top: slot counter, sums, key player and fan hysteresis
// key bits held in a synchronous single-bit memory, results through a 2-entry buffer
// depends on kftc_pkg
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) carries ticks and key bit writes
//   output channel (out_valid_o / out_stall_i / out_data_o) returns one result per transfer
//   configuration port (cfg_valid_i / cfg_ready_o) writes sequence length, fan thresholds
//   and period base; ready is always high, and the user must write only while the block is idle,
//   which is not enforced; each result is registered in the result buffer at its input transfer
// throughput: one item per cycle unless in_stall_o is high; the key bit memory is read
//   every cycle at the next key position, so the read latency is hidden and a write to that entry is forwarded
// stall: a 2-entry result buffer sits between the channels; in_stall_o rises only when
//   both entries hold results that the receiver has not yet taken
// reset: rst_ni clears the slot counter, sums and key position, loads the startup countdown
//   with 8, sets fan on, key off, period 122 and the configuration to its defaults; the key bit
//   memory is not cleared and reads of never-written bits are undefined
`default_nettype none

module keyer_fan_tick_controller_top
  import kftc_pkg::*;
#(
  parameter int KEY_BITS = KeyBitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);

  localparam int PW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int WW = PW + 12;

  // configuration
  logic [10:0] seq_len_q;
  logic [12:0] fan_on_q;
  logic [12:0] fan_off_q;
  logic [7:0]  base_q;

  // state
  logic [3:0]    slot_q, slot_d;
  logic [12:0]   temp_q, temp_d;
  logic [10:0]   speed_q, speed_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [3:0]    startup_q, startup_d;
  logic          fan_q, fan_d;
  logic          key_q, key_d;
  logic [7:0]    period_q, period_d;

  // key bit memory
  logic          key_mem [KEY_BITS];
  logic          rd_bit_q;
  logic          fwd_hit_q;
  logic          fwd_val_q;
  logic          cur_bit;
  logic          mem_we;
  logic [PW-1:0] wr_addr;
  logic [PW+9:0] addr_wide;
  logic          addr_ok;

  // result buffer
  out_item_t  buf_q [2];
  logic [1:0] count_q, count_d;
  logic       rd_ptr_q;
  logic       wr_ptr_q;
  logic       push;
  logic       pop;

  logic       in_acc;
  logic       is_tick;
  logic       key_slot;
  logic       fan_slot;
  logic [9:0] sample;
  logic [10:0] speed_base;
  logic [12:0] temp_base;
  logic [11:0] speed_sum;
  logic [13:0] temp_sum;
  logic [PW:0] pos_next;
  logic        pos_wrap;
  logic [5:0]  drop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (count_q == 2'd2);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign is_tick     = in_acc & (in_data_i.command == CmdTick);

  assign addr_wide = (PW + 10)'(in_data_i.bit_address);
  assign addr_ok   = WW'(in_data_i.bit_address) < WW'(KEY_BITS);
  assign wr_addr   = addr_wide[PW-1:0];
  assign mem_we    = in_acc & (in_data_i.command == CmdWrite) & addr_ok;

  assign cur_bit = fwd_hit_q ? fwd_val_q : rd_bit_q;

  assign sample   = in_data_i.adc_sample & SampleMask;
  assign key_slot = (slot_q[1:0] == KeySlotLow);
  assign fan_slot = (slot_q == FanSlot);
  assign pos_next = {1'b0, pos_q} + (PW + 1)'(1);
  assign pos_wrap = (WW'(pos_next) >= WW'(seq_len_q)) ||
                    (WW'(pos_next) >= WW'(KEY_BITS));
  assign drop     = speed_q[10:5];

  always_comb begin
    slot_d     = slot_q;
    temp_d     = temp_q;
    speed_d    = speed_q;
    pos_d      = pos_q;
    startup_d  = startup_q;
    fan_d      = fan_q;
    key_d      = key_q;
    period_d   = period_q;
    speed_base = speed_q;
    temp_base  = temp_q;
    speed_sum  = '0;
    temp_sum   = '0;
    if (is_tick) begin
      if (key_slot) begin
        key_d      = cur_bit;
        pos_d      = pos_wrap ? '0 : pos_next[PW-1:0];
        period_d   = (8'(drop) >= base_q) ? 8'd0 : (base_q - 8'(drop));
        speed_base = '0;
      end
      if (fan_slot) begin
        if (startup_q != 4'd0) begin
          startup_d = startup_q - 4'd1;
        end else begin
          if (temp_q < fan_on_q) fan_d = 1'b1;
          if (temp_q > fan_off_q) fan_d = 1'b0;
        end
        temp_base = '0;
      end
      speed_sum = 12'(speed_base) + 12'(sample);
      temp_sum  = 14'(temp_base) + 14'(sample);
      if (slot_q[0]) begin
        speed_d = (speed_sum > 12'(SpeedSumMax)) ? SpeedSumMax : speed_sum[10:0];
        temp_d  = temp_base;
      end else begin
        temp_d  = (temp_sum > 14'(TempSumMax)) ? TempSumMax : temp_sum[12:0];
        speed_d = speed_base;
      end
      slot_d = slot_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= SeqLengthReset;
      fan_on_q  <= FanOnReset;
      fan_off_q <= FanOffReset;
      base_q    <= PeriodBaseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSeqLength:    seq_len_q <= cfg_data_i[10:0];
        CfgFanOnThresh:  fan_on_q  <= cfg_data_i;
        CfgFanOffThresh: fan_off_q <= cfg_data_i;
        CfgPeriodBase:   base_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      temp_q    <= '0;
      speed_q   <= '0;
      pos_q     <= '0;
      startup_q <= FanStartupSlots;
      fan_q     <= 1'b1;
      key_q     <= 1'b0;
      period_q  <= PeriodReset;
      fwd_hit_q <= 1'b0;
    end else begin
      slot_q    <= slot_d;
      temp_q    <= temp_d;
      speed_q   <= speed_d;
      pos_q     <= pos_d;
      startup_q <= startup_d;
      fan_q     <= fan_d;
      key_q     <= key_d;
      period_q  <= period_d;
      fwd_hit_q <= mem_we && (wr_addr == pos_d);
    end
  end

  // read at the next key position, forward a same-edge write to that entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[wr_addr] <= in_data_i.bit_value;
    end
    rd_bit_q  <= key_mem[pos_d];
    fwd_val_q <= in_data_i.bit_value;
  end

  // result buffer
  assign push        = in_acc;
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = buf_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= '{key_level: key_d, fan_enable: fan_d, timer_period: period_d};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_write_keeps_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.command == CmdWrite) |=> ($stable(slot_q) && $stable(temp_q)))
    else $error("write command changed tick state");

  a_period_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_tick && key_slot) |=> (period_q <= $past(base_q)))
    else $error("timer period above base");

  a_fan_only_slot9: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(is_tick && fan_slot) |=> $stable(fan_q))
    else $error("fan state changed outside fan slot");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for keyer_fan_tick_controller_top, queue-fed driver and
// monitor with random idle bursts, results checked against an in-bench state predictor
// depends on kftc_pkg and keyer_fan_tick_controller_top
module tb_top;
  import kftc_pkg::*;

  localparam int KeyBits    = KeyBitsDefault;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 110;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic [10:0]        seq_length;
    logic [12:0]        on_thresh;
    logic [12:0]        off_thresh;
    logic [7:0]         base;
    logic [3:0]         slot;
    logic [12:0]        temp_sum;
    logic [10:0]        speed_sum;
    logic [9:0]         key_pos;
    logic [3:0]         startup_left;
    logic               fan_on;
    logic               key_on;
    logic [7:0]         period;
    logic [KeyBits-1:0] key_bits;
  } ctrl_state_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i  = '0;

  ctrl_state_t        dut_model;
  ctrl_state_t        plan_model;
  logic [KeyBits-1:0] loaded;
  in_item_t           pending_items[$];
  out_item_t          expected_outputs[$];
  out_item_t          predicted;
  out_item_t          wanted;
  logic               calm        = 1'b0;
  int                 send_gap    = 0;
  int                 stall_left  = 0;
  int                 fail_count  = 0;
  int                 cycle_count = 0;

  keyer_fan_tick_controller_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void ctrl_step(inout ctrl_state_t s, input in_item_t it,
                                    output out_item_t res);
    logic [10:0] next_pos;
    logic [5:0]  drop;
    logic [13:0] temp_acc;
    logic [11:0] speed_acc;
    logic [9:0]  sample;
    if (it.command == CmdWrite) begin
      s.key_bits[it.bit_address] = it.bit_value;
    end else begin
      sample = it.adc_sample & SampleMask;
      if (s.slot[1:0] == KeySlotLow) begin
        s.key_on = s.key_bits[s.key_pos];
        next_pos = {1'b0, s.key_pos} + 11'd1;
        if (next_pos >= s.seq_length || next_pos >= 11'(KeyBits)) next_pos = '0;
        s.key_pos = next_pos[9:0];
        drop = s.speed_sum[10:5];
        s.period = ({2'b0, drop} >= s.base) ? 8'd0 : s.base - {2'b0, drop};
        s.speed_sum = '0;
      end
      if (s.slot == FanSlot) begin
        if (s.startup_left != 4'd0) begin
          s.startup_left = s.startup_left - 4'd1;
        end else begin
          if (s.temp_sum < s.on_thresh) s.fan_on = 1'b1;
          if (s.temp_sum > s.off_thresh) s.fan_on = 1'b0;
        end
        s.temp_sum = '0;
      end
      if (s.slot[0]) begin
        speed_acc = {1'b0, s.speed_sum} + {2'b0, sample};
        s.speed_sum = (speed_acc > {1'b0, SpeedSumMax}) ? SpeedSumMax : speed_acc[10:0];
      end else begin
        temp_acc = {1'b0, s.temp_sum} + {4'b0, sample};
        s.temp_sum = (temp_acc > {1'b0, TempSumMax}) ? TempSumMax : temp_acc[12:0];
      end
      s.slot = s.slot + 4'd1;
    end
    res.key_level    = s.key_on;
    res.fan_enable   = s.fan_on;
    res.timer_period = s.period;
  endfunction

  function automatic void ctrl_set_reg(inout ctrl_state_t s, input logic [1:0] idx,
                                       input logic [12:0] val);
    case (idx)
      CfgSeqLength:    s.seq_length = val[10:0];
      CfgFanOnThresh:  s.on_thresh  = val;
      CfgFanOffThresh: s.off_thresh = val;
      CfgPeriodBase:   s.base       = val[7:0];
      default:         ;
    endcase
  endfunction

  // a tick that plays a never-loaded key bit gets a write of that bit queued first
  task automatic plan_item(input logic cmd, input logic [9:0] sample,
                           input logic [9:0] addr, input logic value);
    in_item_t  item;
    out_item_t ignored;
    if (cmd == CmdTick && plan_model.slot[1:0] == KeySlotLow &&
        !loaded[plan_model.key_pos]) begin
      item.command     = CmdWrite;
      item.adc_sample  = 10'($urandom);
      item.bit_address = plan_model.key_pos;
      item.bit_value   = 1'($urandom);
      loaded[item.bit_address] = 1'b1;
      ctrl_step(plan_model, item, ignored);
      pending_items.push_back(item);
    end
    item.command     = cmd;
    item.adc_sample  = sample;
    item.bit_address = addr;
    item.bit_value   = value;
    if (cmd == CmdWrite) loaded[addr] = 1'b1;
    ctrl_step(plan_model, item, ignored);
    pending_items.push_back(item);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_outputs.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ctrl_set_reg(dut_model, idx, val);
    ctrl_set_reg(plan_model, idx, val);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        ctrl_step(dut_model, in_data_i, predicted);
        expected_outputs.push_back(predicted);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap   <= $urandom_range(0, 16);
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_outputs.size() == 0) begin
          $error("result transfer with no expected output");
          fail_count++;
        end else begin
          wanted = expected_outputs.pop_front();
          if (out_data_o.key_level !== wanted.key_level) begin
            $error("key_level: expected %0d, got %0d", wanted.key_level,
                   out_data_o.key_level);
            fail_count++;
          end
          if (out_data_o.fan_enable !== wanted.fan_enable) begin
            $error("fan_enable: expected %0d, got %0d", wanted.fan_enable,
                   out_data_o.fan_enable);
            fail_count++;
          end
          if (out_data_o.timer_period !== wanted.timer_period) begin
            $error("timer_period: expected %0d, got %0d", wanted.timer_period,
                   out_data_o.timer_period);
            fail_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left  <= $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [9:0] warm_samples [16];
    logic       write_cfg;
    int         phase;
    int         n;
    int         center;
    int         sample;
    int         seq;
    int         on_t;
    int         off_t;
    int         base;

    warm_samples = '{10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1023,
                     10'd1023, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'd1023, 10'd0,
                     10'd1023, 10'd1023};
    dut_model.seq_length   = SeqLengthReset;
    dut_model.on_thresh    = FanOnReset;
    dut_model.off_thresh   = FanOffReset;
    dut_model.base         = PeriodBaseReset;
    dut_model.slot         = '0;
    dut_model.temp_sum     = '0;
    dut_model.speed_sum    = '0;
    dut_model.key_pos      = '0;
    dut_model.startup_left = FanStartupSlots;
    dut_model.fan_on       = 1'b1;
    dut_model.key_on       = 1'b0;
    dut_model.period       = PeriodReset;
    dut_model.key_bits     = '0;
    plan_model = dut_model;
    loaded     = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, writes at the play position, one full slot cycle
    plan_item(CmdWrite, 10'd1023, 10'd0, 1'b1);
    plan_item(CmdWrite, 10'd0, 10'd1023, 1'b1);
    plan_item(CmdWrite, 10'h2AA, 10'h2AA, 1'b0);
    plan_item(CmdWrite, 10'h155, 10'h155, 1'b1);
    for (n = 0; n < 16; n++) begin
      if (n == 4) plan_item(CmdWrite, 10'd0, 10'd0, 1'b0);
      if (n == 8) plan_item(CmdWrite, 10'd1023, 10'd0, 1'b1);
      plan_item(CmdTick, warm_samples[n], 10'($urandom), 1'($urandom));
    end

    for (phase = 0; phase < PhaseCount; phase++) begin
      wait_drained();
      calm      = (phase >= PhaseCount - 2);
      center    = $urandom_range(0, 1023);
      write_cfg = 1'b1;
      case (phase)
        0, 5: write_cfg = 1'b0;
        1: begin
          seq = 1024; on_t = 4000; off_t = 4100; base = 200;
        end
        2: begin
          seq = 0; on_t = 0; off_t = 8184; base = 255;
        end
        3: begin
          seq = 2047; on_t = 8184; off_t = 0; base = 0;
        end
        4: begin
          center = 1000; seq = 5; on_t = 3000; off_t = 3400; base = 20;
        end
        default: begin
          seq   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) :
                                                $urandom_range(1, 16);
          on_t  = 8 * center - int'($urandom_range(0, 500));
          off_t = 8 * center + int'($urandom_range(0, 500));
          base  = $urandom_range(0, 255);
          if (on_t < 0) on_t = 0;
          if (off_t > 8184) off_t = 8184;
        end
      endcase
      if (write_cfg) begin
        write_reg(CfgSeqLength, 13'(seq));
        write_reg(CfgFanOnThresh, 13'(on_t));
        write_reg(CfgFanOffThresh, 13'(off_t));
        write_reg(CfgPeriodBase, 13'(base));
      end
      for (n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          plan_item(CmdWrite, 10'($urandom),
                    $urandom_range(0, 1) ? plan_model.key_pos : 10'($urandom),
                    1'($urandom));
        end else begin
          case ($urandom_range(0, 3))
            0:       sample = $urandom_range(0, 1023);
            1:       sample = $urandom_range(0, 1) ? 1023 : 0;
            default: sample = center + int'($urandom_range(0, 128)) - 64;
          endcase
          if (sample < 0) sample = 0;
          if (sample > 1023) sample = 1023;
          plan_item(CmdTick, 10'(sample), 10'($urandom), 1'($urandom));
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
